### sv/acc_pkg.sv
// Package for the box contact classifier: shared types and default constants.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package acc_pkg;

  localparam int CoordBitsDefault  = 16;
  localparam int QueueDepthDefault = 2;

  typedef enum logic [2:0] {
    SIDE_UP     = 3'd0,
    SIDE_DOWN   = 3'd1,
    SIDE_LEFT   = 3'd2,
    SIDE_RIGHT  = 3'd3,
    SIDE_CENTRE = 3'd4
  } side_e;

  typedef enum logic [1:0] {
    PH_NONE      = 2'd0,
    PH_STARTED   = 2'd1,
    PH_CONTINUED = 2'd2
  } phase_e;

  // Classification of one pair as it travels from the front to the back.
  typedef struct packed {
    logic  hit;
    side_e side;
    logic  push;
    logic  last;
  } acc_ctrl_t;

endpackage

### sv/acc_front.sv
// Front of the box contact classifier: overlap test, corner counts, side choice
// and doubled resolved coordinate for one pair. Depends on acc_pkg.
`timescale 1ns / 1ps

module acc_front import acc_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic signed [COORD_BITS-1:0] own_x_i,
  input  logic signed [COORD_BITS-1:0] own_y_i,
  input  logic        [COORD_BITS-2:0] own_w_i,
  input  logic        [COORD_BITS-2:0] own_h_i,
  input  logic                         own_is_box_i,
  input  logic signed [COORD_BITS-1:0] other_x_i,
  input  logic signed [COORD_BITS-1:0] other_y_i,
  input  logic        [COORD_BITS-2:0] other_w_i,
  input  logic        [COORD_BITS-2:0] other_h_i,
  input  logic                         other_is_box_i,
  input  logic                         other_blocks_i,
  input  logic                         frame_last_i,
  output acc_ctrl_t                    ctrl_o,
  output logic signed [COORD_BITS+1:0] resolve_x2_o,
  output logic signed [COORD_BITS+1:0] resolve_y2_o
);

  localparam int W2 = COORD_BITS + 2;

  logic signed [W2-1:0] ox2, oy2, cx2, cy2, ow, oh, cw, ch, sx, sy;
  logic signed [W2-1:0] ox_lo, ox_hi, oy_lo, oy_hi;
  logic                 overlap;
  logic [1:0]           cnt_left, cnt_right, cnt_up, cnt_down;
  logic [1:0]           best_lr, best_ud, best;

  // Doubled coordinates keep the half sizes exact.
  assign ox2 = {own_x_i[COORD_BITS-1], own_x_i, 1'b0};
  assign oy2 = {own_y_i[COORD_BITS-1], own_y_i, 1'b0};
  assign cx2 = {other_x_i[COORD_BITS-1], other_x_i, 1'b0};
  assign cy2 = {other_y_i[COORD_BITS-1], other_y_i, 1'b0};
  assign ow  = {3'b000, own_w_i};
  assign oh  = {3'b000, own_h_i};
  assign cw  = {3'b000, other_w_i};
  assign ch  = {3'b000, other_h_i};
  assign sx  = ow + cw;
  assign sy  = oh + ch;

  assign ox_lo = ox2 - ow;
  assign ox_hi = ox2 + ow;
  assign oy_lo = oy2 - oh;
  assign oy_hi = oy2 + oh;

  assign overlap = own_is_box_i && other_is_box_i &&
                   (ox_lo < cx2 + cw) && (cx2 - cw < ox_hi) &&
                   (oy_lo < cy2 + ch) && (cy2 - ch < oy_hi);

  // Counts are kept in pairs of corners; only their order matters.
  assign cnt_left  = {1'b0, ox_lo < cx2} + {1'b0, ox_hi < cx2};
  assign cnt_right = {1'b0, ox_lo > cx2} + {1'b0, ox_hi > cx2};
  assign cnt_up    = {1'b0, oy_lo < cy2} + {1'b0, oy_hi < cy2};
  assign cnt_down  = {1'b0, oy_lo > cy2} + {1'b0, oy_hi > cy2};

  assign best_lr = (cnt_right > cnt_left) ? cnt_right : cnt_left;
  assign best_ud = (cnt_down > cnt_up) ? cnt_down : cnt_up;
  assign best    = (best_ud > best_lr) ? best_ud : best_lr;

  always_comb begin
    ctrl_o.hit   = overlap;
    ctrl_o.side  = SIDE_UP;
    ctrl_o.push  = overlap && other_blocks_i;
    ctrl_o.last  = frame_last_i;
    resolve_x2_o = '0;
    resolve_y2_o = '0;
    if (overlap) begin
      priority if (best == cnt_up) begin
        ctrl_o.side  = SIDE_UP;
        resolve_y2_o = cy2 - sy;
      end else if (best == cnt_down) begin
        ctrl_o.side  = SIDE_DOWN;
        resolve_y2_o = cy2 + sy;
      end else if (best == cnt_left) begin
        ctrl_o.side  = SIDE_LEFT;
        resolve_x2_o = cx2 - sx;
      end else begin
        ctrl_o.side  = SIDE_RIGHT;
        resolve_x2_o = cx2 + sx;
      end
    end
  end

endmodule

### sv/acc_queue.sv
// Short first-in first-out queue of register entries between front and back.
// Generic in width and depth; depends on acc_pkg for the default depth.
`timescale 1ns / 1ps

module acc_queue import acc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == FullCnt);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond depth");

  a_full_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o)
    else $error("full queue lost an entry without a pop");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

### sv/acc_back.sv
// Back of the box contact classifier: frame hit accumulation, contact state
// step on the frame's last item, and the output register. Depends on acc_pkg.
`timescale 1ns / 1ps

module acc_back import acc_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  acc_ctrl_t                    q_ctrl_i,
  input  logic signed [COORD_BITS+1:0] q_rx_i,
  input  logic signed [COORD_BITS+1:0] q_ry_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [2:0]                   side_o,
  output logic signed [COORD_BITS+1:0] resolve_x2_o,
  output logic signed [COORD_BITS+1:0] resolve_y2_o,
  output logic                         push_out_o,
  output logic [1:0]                   contact_state_o
);

  logic                         out_valid_q;
  logic                         frame_hit_q, frame_hit_d;
  phase_e                       phase_q, phase_d;
  acc_ctrl_t                    ctrl_q;
  logic signed [COORD_BITS+1:0] rx_q, ry_q;
  logic                         any_hit;

  // The output register takes a new transaction whenever it is empty or drained.
  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);
  assign any_hit = frame_hit_q || q_ctrl_i.hit;

  always_comb begin
    frame_hit_d = frame_hit_q;
    phase_d     = phase_q;
    if (q_pop_o) begin
      if (q_ctrl_i.last) begin
        frame_hit_d = 1'b0;
        if (!any_hit) begin
          phase_d = PH_NONE;
        end else begin
          unique case (phase_q)
            PH_NONE: phase_d = PH_STARTED;
            default: phase_d = PH_CONTINUED;
          endcase
        end
      end else begin
        frame_hit_d = any_hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      frame_hit_q <= 1'b0;
      phase_q     <= PH_NONE;
    end else begin
      frame_hit_q <= frame_hit_d;
      phase_q     <= phase_d;
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ctrl_q <= q_ctrl_i;
      rx_q   <= q_rx_i;
      ry_q   <= q_ry_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = ctrl_q.hit;
  assign side_o          = ctrl_q.side;
  assign resolve_x2_o    = rx_q;
  assign resolve_y2_o    = ry_q;
  assign push_out_o      = ctrl_q.push;
  assign contact_state_o = phase_q;

  a_push_needs_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ctrl_q.push) |-> ctrl_q.hit)
    else $error("push flagged without a hit");

  a_miss_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ctrl_q.hit) |->
      (ctrl_q.side == SIDE_UP && rx_q == '0 && ry_q == '0))
    else $error("miss carries a side or a coordinate");

  a_frame_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_ctrl_i.last) |=> !frame_hit_q)
    else $error("frame hit not cleared at frame end");

  a_started_needs_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_ctrl_i.last && !any_hit) |=> (phase_q == PH_NONE))
    else $error("contact state kept over a frame without a hit");

endmodule

### sv/aabb_contact_classifier.sv
// Top level of the box contact classifier: front classifier, queue and back.
// Depends on acc_pkg, acc_front, acc_queue and acc_back.
//
// Usage: each input transaction on in_valid_i / in_ready_o pairs the own box
// with one other collider. Every input transaction yields exactly one result
// transaction on out_valid_o / out_ready_i: hit, side, the doubled resolved
// coordinate, a push flag for blocking colliders and the contact state.
// The front classifies a pair combinationally and writes it into a short
// queue; the back pops the queue into the output register and steps the
// frame state on items marked frame_last.
// An accepted input is written into the queue, and the back then loads it
// into the output register once that register is free; out_valid_o rises
// with that load. Throughput is one pair per cycle while the receiver takes
// every result, set by the combinational front classifier and the
// one-per-cycle queue pop. When the receiver stalls the output register
// holds its result and the queue fills; in_ready_o drops only when the
// queue is full. Reset clears the queue, the output valid, the frame hit
// flag and the contact state (none).
`timescale 1ns / 1ps

module aabb_contact_classifier import acc_pkg::*; #(
  parameter int COORD_BITS  = CoordBitsDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] own_x_i,
  input  logic signed [COORD_BITS-1:0] own_y_i,
  input  logic        [COORD_BITS-2:0] own_w_i,
  input  logic        [COORD_BITS-2:0] own_h_i,
  input  logic                         own_is_box_i,
  input  logic signed [COORD_BITS-1:0] other_x_i,
  input  logic signed [COORD_BITS-1:0] other_y_i,
  input  logic        [COORD_BITS-2:0] other_w_i,
  input  logic        [COORD_BITS-2:0] other_h_i,
  input  logic                         other_is_box_i,
  input  logic                         other_blocks_i,
  input  logic                         frame_last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [2:0]                   side_o,
  output logic signed [COORD_BITS+1:0] resolve_x2_o,
  output logic signed [COORD_BITS+1:0] resolve_y2_o,
  output logic                         push_out_o,
  output logic [1:0]                   contact_state_o
);

  localparam int W2    = COORD_BITS + 2;
  localparam int QWIDTH = $bits(acc_ctrl_t) + 2 * W2;

  acc_ctrl_t                    f_ctrl, q_ctrl;
  logic signed [W2-1:0]         f_rx, f_ry, q_rx, q_ry;
  logic [QWIDTH-1:0]            q_wdata, q_rdata;
  logic                         q_full, q_valid, q_pop;

  acc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .own_x_i       (own_x_i),
    .own_y_i       (own_y_i),
    .own_w_i       (own_w_i),
    .own_h_i       (own_h_i),
    .own_is_box_i  (own_is_box_i),
    .other_x_i     (other_x_i),
    .other_y_i     (other_y_i),
    .other_w_i     (other_w_i),
    .other_h_i     (other_h_i),
    .other_is_box_i(other_is_box_i),
    .other_blocks_i(other_blocks_i),
    .frame_last_i  (frame_last_i),
    .ctrl_o        (f_ctrl),
    .resolve_x2_o  (f_rx),
    .resolve_y2_o  (f_ry)
  );

  assign q_wdata    = {f_ctrl, f_rx, f_ry};
  assign in_ready_o = !q_full;

  acc_queue #(
    .WIDTH(QWIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_rdata)
  );

  assign {q_ctrl, q_rx, q_ry} = q_rdata;

  acc_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_ctrl_i       (q_ctrl),
    .q_rx_i         (q_rx),
    .q_ry_i         (q_ry),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .side_o         (side_o),
    .resolve_x2_o   (resolve_x2_o),
    .resolve_y2_o   (resolve_y2_o),
    .push_out_o     (push_out_o),
    .contact_state_o(contact_state_o)
  );

endmodule
